[rtl/assert_macros.svh]
// Assertion helpers; clk and arst_n must be visible where these are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/bolt_pkg.sv]
package bolt_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int PAYLOAD_BITS_DEF = 32;
	localparam int KEY_W = 32;
	localparam int FIELD_PAY_W = 32;
	localparam int POS_W = 7;
	localparam int CNT_OUT_W = 7;

	typedef enum logic [2:0] {
		CMD_INS_TAIL = 3'd0,
		CMD_INS_HEAD = 3'd1,
		CMD_INS_SORT = 3'd2,
		CMD_RM_TAIL  = 3'd3,
		CMD_RM_HEAD  = 3'd4,
		CMD_RM_KEY   = 3'd5,
		CMD_READ_POS = 3'd6,
		CMD_FIND_KEY = 3'd7
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_UP_RD,
		ST_UP_WR,
		ST_PUT,
		ST_DN_RD,
		ST_DN_WR,
		ST_FETCH_RD,
		ST_FETCH,
		ST_DONE
	} st_t;

	typedef struct packed {
		cmd_t                     cmd;
		logic signed [KEY_W-1:0]  entry_key;
		logic [FIELD_PAY_W-1:0]   entry_payload;
		logic [POS_W-1:0]         position;
	} req_t;

	typedef struct packed {
		logic                     ok;
		logic signed [KEY_W-1:0]  found_key;
		logic [FIELD_PAY_W-1:0]   found_payload;
		logic [CNT_OUT_W-1:0]     count;
		logic                     is_full;
		logic                     is_empty;
	} rsp_t;

	// Outcome of one request as the sequencer hands it over.
	typedef struct packed {
		logic                     ok;
		logic signed [KEY_W-1:0]  found_key;
		logic [FIELD_PAY_W-1:0]   found_payload;
	} res_t;

endpackage

[rtl/bolt_mem.sv]
module bolt_mem import bolt_pkg::*; #(
	parameter int DEPTH = CAPACITY_DEF,
	parameter int SW = FIELD_PAY_W,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                    clk,
	input  logic                    wr_en,
	input  logic [AW-1:0]           wr_addr,
	input  logic signed [KEY_W-1:0] wr_key,
	input  logic [SW-1:0]           wr_pay,
	input  logic [AW-1:0]           rd_addr,
	output logic signed [KEY_W-1:0] rd_key,
	output logic [SW-1:0]           rd_pay
);

	logic signed [KEY_W-1:0] key_mem [DEPTH];
	logic [SW-1:0]           pay_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr] <= wr_key;
			pay_mem[wr_addr] <= wr_pay;
		end
	end

	always_ff @(posedge clk) begin
		rd_key <= key_mem[rd_addr];
		rd_pay <= pay_mem[rd_addr];
	end

endmodule

[rtl/bolt_ctrl.sv]
module bolt_ctrl import bolt_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
	localparam int SW = (PAYLOAD_BITS < FIELD_PAY_W) ? PAYLOAD_BITS : FIELD_PAY_W,
	localparam int AW = $clog2(CAPACITY),
	localparam int CW = $clog2(CAPACITY + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	output logic                    req_ready,
	input  req_t                    req,
	output logic                    res_valid,
	input  logic                    res_ready,
	output res_t                    res,
	output logic [CW-1:0]           count,
	output logic                    wr_en,
	output logic [AW-1:0]           wr_addr,
	output logic signed [KEY_W-1:0] wr_key,
	output logic [SW-1:0]           wr_pay,
	output logic [AW-1:0]           rd_addr,
	input  logic signed [KEY_W-1:0] rd_key,
	input  logic [SW-1:0]           rd_pay
);

	st_t                     state_q, state_d;
	logic [CW-1:0]           cnt_q, cnt_d;
	cmd_t                    cmd_q, cmd_d;
	logic signed [KEY_W-1:0] key_q, key_d;
	logic [SW-1:0]           pay_q, pay_d;
	logic [POS_W-1:0]        pos_q, pos_d;
	logic [CW-1:0]           idx_q, idx_d;
	logic [CW-1:0]           tgt_q, tgt_d;
	logic                    ok_q, ok_d;
	logic signed [KEY_W-1:0] fkey_q, fkey_d;
	logic [FIELD_PAY_W-1:0]  fpay_q, fpay_d;

	logic          full, empty, pos_hit;
	logic          key_lt, key_eq;
	logic [CW-1:0] idx_m1, idx_p1;

	// Shared compare unit: stored key against the request key.
	assign key_lt = rd_key < key_q;
	assign key_eq = rd_key == key_q;

	assign full    = cnt_q == CW'(CAPACITY);
	assign empty   = cnt_q == '0;
	assign pos_hit = (req.position != '0) && (32'(req.position) <= 32'(cnt_q));
	assign idx_m1  = idx_q - CW'(1);
	assign idx_p1  = idx_q + CW'(1);

	assign count = cnt_q;
	assign res   = '{ok: ok_q, found_key: fkey_q, found_payload: fpay_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q  <= cmd_d;
		key_q  <= key_d;
		pay_q  <= pay_d;
		pos_q  <= pos_d;
		idx_q  <= idx_d;
		tgt_q  <= tgt_d;
		ok_q   <= ok_d;
		fkey_q <= fkey_d;
		fpay_q <= fpay_d;
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd_d   = cmd_q;
		key_d   = key_q;
		pay_d   = pay_q;
		pos_d   = pos_q;
		idx_d   = idx_q;
		tgt_d   = tgt_q;
		ok_d    = ok_q;
		fkey_d  = fkey_q;
		fpay_d  = fpay_q;

		req_ready = state_q == ST_IDLE;
		res_valid = state_q == ST_DONE;
		wr_en     = 1'b0;
		wr_addr   = tgt_q[AW-1:0];
		wr_key    = key_q;
		wr_pay    = pay_q;
		rd_addr   = idx_q[AW-1:0];

		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd_d   = req.cmd;
					key_d   = req.entry_key;
					pay_d   = req.entry_payload[SW-1:0];
					pos_d   = req.position;
					ok_d    = 1'b0;
					fkey_d  = '0;
					fpay_d  = '0;
					idx_d   = '0;
					state_d = ST_DONE;
					case (req.cmd)
						CMD_INS_TAIL: begin
							if (!full) begin
								tgt_d   = cnt_q;
								state_d = ST_PUT;
							end
						end
						CMD_INS_HEAD: begin
							if (!full) begin
								tgt_d   = '0;
								idx_d   = cnt_q;
								state_d = ST_UP_RD;
							end
						end
						CMD_INS_SORT: begin
							if (!full)
								state_d = ST_SCAN_RD;
						end
						CMD_RM_TAIL: begin
							if (!empty) begin
								cnt_d = cnt_q - CW'(1);
								ok_d  = 1'b1;
							end
						end
						CMD_RM_HEAD: begin
							if (!empty)
								state_d = ST_DN_RD;
						end
						CMD_RM_KEY, CMD_FIND_KEY: begin
							state_d = ST_SCAN_RD;
						end
						CMD_READ_POS: begin
							if (pos_hit)
								state_d = ST_FETCH_RD;
						end
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_SCAN_RD: begin
				if (idx_q == cnt_q) begin
					// no stop point: sorted insert goes to the tail
					if (cmd_q == CMD_INS_SORT) begin
						tgt_d   = idx_q;
						state_d = ST_UP_RD;
					end else begin
						state_d = ST_DONE;
					end
				end else begin
					state_d = ST_SCAN_CMP;
				end
			end
			ST_SCAN_CMP: begin
				if (cmd_q == CMD_INS_SORT) begin
					if (!key_lt) begin
						tgt_d   = idx_q;
						idx_d   = cnt_q;
						state_d = ST_UP_RD;
					end else begin
						idx_d   = idx_p1;
						state_d = ST_SCAN_RD;
					end
				end else if (key_eq) begin
					if (cmd_q == CMD_FIND_KEY) begin
						ok_d    = 1'b1;
						fkey_d  = rd_key;
						fpay_d  = FIELD_PAY_W'(rd_pay);
						state_d = ST_DONE;
					end else begin
						state_d = ST_DN_RD;
					end
				end else begin
					idx_d   = idx_p1;
					state_d = ST_SCAN_RD;
				end
			end
			ST_UP_RD: begin
				if (idx_q == tgt_q) begin
					state_d = ST_PUT;
				end else begin
					rd_addr = idx_m1[AW-1:0];
					state_d = ST_UP_WR;
				end
			end
			ST_UP_WR: begin
				wr_en   = 1'b1;
				wr_addr = idx_q[AW-1:0];
				wr_key  = rd_key;
				wr_pay  = rd_pay;
				idx_d   = idx_m1;
				state_d = ST_UP_RD;
			end
			ST_PUT: begin
				wr_en   = 1'b1;
				cnt_d   = cnt_q + CW'(1);
				ok_d    = 1'b1;
				state_d = ST_DONE;
			end
			ST_DN_RD: begin
				if (idx_p1 >= cnt_q) begin
					cnt_d   = cnt_q - CW'(1);
					ok_d    = 1'b1;
					state_d = ST_DONE;
				end else begin
					rd_addr = idx_p1[AW-1:0];
					state_d = ST_DN_WR;
				end
			end
			ST_DN_WR: begin
				wr_en   = 1'b1;
				wr_addr = idx_q[AW-1:0];
				wr_key  = rd_key;
				wr_pay  = rd_pay;
				idx_d   = idx_p1;
				state_d = ST_DN_RD;
			end
			ST_FETCH_RD: begin
				rd_addr = AW'(pos_q - POS_W'(1));
				state_d = ST_FETCH;
			end
			ST_FETCH: begin
				ok_d    = 1'b1;
				fkey_d  = rd_key;
				fpay_d  = FIELD_PAY_W'(rd_pay);
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (res_ready)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

[rtl/bounded_ordered_list_table.sv]
// Tail remove and refused requests go straight from acceptance to the response; tail
// insert writes one entry, read by position reads one entry, and the other commands
// scan or move entries. Requests are taken one at a time; each list entry scanned or
// moved uses the single read port of the entry memory. A finished response may wait
// while the next request is accepted. Reset clears the entry count and control state;
// the entry memory is not cleared, and no clearing pass runs.
`include "assert_macros.svh"

module bounded_ordered_list_table import bolt_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int SW = (PAYLOAD_BITS < FIELD_PAY_W) ? PAYLOAD_BITS : FIELD_PAY_W;
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic                    res_valid, res_ready;
	res_t                    res;
	logic [CW-1:0]           entry_count;
	logic                    wr_en;
	logic [AW-1:0]           wr_addr, rd_addr;
	logic signed [KEY_W-1:0] wr_key, rd_key;
	logic [SW-1:0]           wr_pay, rd_pay;

	logic rsp_valid_q;
	rsp_t rsp_q;

	bolt_ctrl #(
		.CAPACITY     (CAPACITY),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.count     (entry_count),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_key    (wr_key),
		.wr_pay    (wr_pay),
		.rd_addr   (rd_addr),
		.rd_key    (rd_key),
		.rd_pay    (rd_pay)
	);

	bolt_mem #(
		.DEPTH (CAPACITY),
		.SW    (SW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_key  (wr_key),
		.wr_pay  (wr_pay),
		.rd_addr (rd_addr),
		.rd_key  (rd_key),
		.rd_pay  (rd_pay)
	);

	// Take a new response when the output slot is empty or being drained.
	assign res_ready = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q.ok            <= res.ok;
			rsp_q.found_key     <= res.found_key;
			rsp_q.found_payload <= res.found_payload;
			rsp_q.count         <= CNT_OUT_W'(entry_count);
			rsp_q.is_full       <= entry_count == CW'(CAPACITY);
			rsp_q.is_empty      <= entry_count == '0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`ASSERT_ALWAYS(a_count_bound, entry_count <= CW'(CAPACITY), "entry count beyond capacity")
	`ASSERT_IMPLIES(a_fail_zero, rsp_valid && !rsp.ok, rsp.found_key == '0 && rsp.found_payload == '0, "failed response carries data")
	`ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready, "ready right after a request")
	`ASSERT_IMPLIES(a_flags_excl, rsp_valid, !(rsp.is_full && rsp.is_empty), "full and empty together")

endmodule
